[hw/rtl/ascii_number_parse_and_byteswap_unit_assert.svh]
// assertion macros used by the checker file
`ifndef ASCII_NUMBER_PARSE_AND_BYTESWAP_UNIT_ASSERT_SVH
`define ASCII_NUMBER_PARSE_AND_BYTESWAP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ANPBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ANPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/anpbs_pkg.sv]
// ----------------------------------------------------------------------------
// anpbs_pkg
// Shared constants, types and helper functions of the ascii number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anpbs_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned POS_W  = 6;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_X     = 8'd120;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_A     = 8'd97;
    localparam logic [CHAR_W-1:0] CH_F     = 8'd102;
    localparam logic [POS_W-1:0]  POS_MAX  = 6'd63;

    // one item handed from the input register to the accumulator
    typedef struct packed {
        logic              en;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } anpbs_step_t;

    function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_A && c <= CH_F)
        begin
            d = c - CH_A + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/anpbs_accum.sv]
// ----------------------------------------------------------------------------
// anpbs_accum
// Token state and accumulate step: one character per enabled cycle, gives
// the two's-complement pattern the token would have if it ended here.
// ----------------------------------------------------------------------------
`default_nettype none

module anpbs_accum
    import anpbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire anpbs_step_t       step,
    output logic [WORD_W-1:0]      pattern
);

    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              hex_reg;
    logic              hex_next;
    logic              neg_reg;
    logic              neg_next;

    always_comb
    begin
        acc_next = acc_reg;
        hex_next = hex_reg;
        neg_next = neg_reg;
        if (pos_reg == '0 && step.char_code == CH_MINUS)
        begin
            neg_next = 1'b1;
        end
        else if (pos_reg == POS_W'(1) && !hex_reg && step.char_code == CH_X)
        begin
            // 0x prefix: restart as hex, drop any sign
            hex_next = 1'b1;
            acc_next = '0;
            neg_next = 1'b0;
        end
        else if (hex_reg)
        begin
            // times 16 plus digit
            acc_next = {acc_reg[WORD_W-5:0], 4'b0000}
                     + {{(WORD_W-4){1'b0}}, hex_digit(step.char_code)};
        end
        else
        begin
            // times 10 as 8x + 2x, non-digits still add their code minus '0'
            acc_next = {acc_reg[WORD_W-4:0], 3'b000} + {acc_reg[WORD_W-2:0], 1'b0}
                     + {{(WORD_W-CHAR_W){1'b0}}, step.char_code}
                     - {{(WORD_W-CHAR_W){1'b0}}, CH_ZERO};
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    end

    assign pattern = neg_next ? (WORD_W'(0) - acc_next) : acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            hex_reg <= 1'b0;
            neg_reg <= 1'b0;
        end
        else if (step.en)
        begin
            if (step.last_char)
            begin
                acc_reg <= '0;
                pos_reg <= '0;
                hex_reg <= 1'b0;
                neg_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                pos_reg <= pos_next;
                hex_reg <= hex_next;
                neg_reg <= neg_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ascii_number_parse_and_byteswap_unit.sv]
// ----------------------------------------------------------------------------
// ascii_number_parse_and_byteswap_unit
// Parses a decimal or 0x-hex ascii token one character per item and gives
// its 32-bit pattern, signed reading and byte-swapped pattern.
// ----------------------------------------------------------------------------
// Takes one character item per clock while in_stall is low. Each item passes
// an input register and then the accumulate step; the item marked last_char
// loads the result register, which shows the token's result with out_valid.
// A token may start on the cycle after the previous token's last character.
// in_stall rises only while a last character waits in the input register
// and the result register still holds a stalled result.
`default_nettype none

module ascii_number_parse_and_byteswap_unit
    import anpbs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [CHAR_W-1:0]        char_code,
    input  wire logic                     last_char,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [WORD_W-1:0]             bit_pattern,
    output logic signed [WORD_W-1:0]      signed_value,
    output logic [WORD_W-1:0]             swapped_pattern
);

    logic              in_v_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              fire;
    logic              out_v_reg;
    logic [WORD_W-1:0] pat_reg;
    logic [WORD_W-1:0] pattern;
    anpbs_step_t       step;

    // a held last character moves on only if the result register frees up
    assign fire     = in_v_reg && (!last_reg || !out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !fire;

    assign step.en        = fire;
    assign step.char_code = char_reg;
    assign step.last_char = last_reg;

    anpbs_accum u_accum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pattern (pattern)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_v_reg <= in_valid;
            end
            if (fire && last_reg)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
        if (fire && last_reg)
        begin
            pat_reg <= pattern;
        end
    end

    assign out_valid       = out_v_reg;
    assign bit_pattern     = pat_reg;
    assign signed_value    = $signed(pat_reg);
    assign swapped_pattern = swap_bytes(pat_reg);

endmodule

`default_nettype wire

[hw/rtl/anpbs_checker.sv]
// ----------------------------------------------------------------------------
// anpbs_checker
// Port-level checks of the ascii number parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_number_parse_and_byteswap_unit_assert.svh"

module anpbs_checker
    import anpbs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [CHAR_W-1:0]        char_code,
    input  wire logic                     last_char,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic [WORD_W-1:0]        bit_pattern,
    input  wire logic signed [WORD_W-1:0] signed_value,
    input  wire logic [WORD_W-1:0]        swapped_pattern
);

    logic [CHAR_W:0] in_item;

    assign in_item = {char_code, last_char};

    // held result keeps its value
    `ANPBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bit_pattern), "stalled result changed")

    // stalled input item keeps its value
    `ANPBS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item), "stalled item changed")

    // input side backs up only behind a stalled result
    `ANPBS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled result")

    `ANPBS_ASSERT_NOW(a_signed_same, out_valid, $unsigned(signed_value) == bit_pattern, "signed value differs from pattern")

    `ANPBS_ASSERT_NOW(a_swap_bytes, out_valid, (swapped_pattern[31:24] == bit_pattern[7:0]) && (swapped_pattern[23:16] == bit_pattern[15:8]) && (swapped_pattern[15:8] == bit_pattern[23:16]) && (swapped_pattern[7:0] == bit_pattern[31:24]), "swapped pattern wrong")

endmodule

bind ascii_number_parse_and_byteswap_unit anpbs_checker u_anpbs_checker (.*);

`default_nettype wire
